// ----- hdl/bounded_queue_sorted_insert_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sorted queue block
// Immediate-implication and next-cycle-implication checks on the clock.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_QUEUE_SORTED_INSERT_TOP_MACROS_SVH
`define BOUNDED_QUEUE_SORTED_INSERT_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BQSI_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define BQSI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/bqsi_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqsi_pkg
// Shared constants, operation codes and types of the sorted queue block.
// ---------------------------------------------------------------------------
package bqsi_pkg;

   // Storage depth; a power of two so the ring pointers wrap by truncation.
   localparam int CAPACITY = 64;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int KIND_W   = 3;
   localparam int VAL_W    = 32;
   localparam int ENT_W    = 31;
   localparam int IDX_W    = 6;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

   localparam logic signed [VAL_W-1:0] NO_DATA = '1;

   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      logic [ENT_W-1:0] wdata;
      logic             re;
      logic [PTR_W-1:0] raddr;
   } ram_cmd_type;

   typedef struct packed {
      logic                    ok;
      logic signed [VAL_W-1:0] data;
      logic [CNT_W-1:0]        count;
      logic                    empty_res;
   } result_type;

endpackage

// ----- hdl/bqsi_req_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqsi_req_if
// Request channel: operation kind, value and read index.
// ---------------------------------------------------------------------------
interface bqsi_req_if;
   import bqsi_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic signed [VAL_W-1:0] value;
   logic [IDX_W-1:0]        index;

   modport source (output valid, kind, value, index, input ready);
   modport sink   (input valid, kind, value, index, output ready);
endinterface

// ----- hdl/bqsi_rsp_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqsi_rsp_if
// Response channel: status, data, entry count and empty flag.
// ---------------------------------------------------------------------------
interface bqsi_rsp_if;
   import bqsi_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic signed [VAL_W-1:0] data;
   logic [CNT_W-1:0]        count;
   logic                    empty_res;

   modport source (output valid, ok, data, count, empty_res, input ready);
   modport sink   (input valid, ok, data, count, empty_res, output ready);
endinterface

// ----- hdl/bounded_queue_sorted_insert_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_queue_sorted_insert_top
// Bounded ordered store of up to 64 non-negative values with push, pop,
// ordered insert, erase-all-equal, indexed read and clear.
// ---------------------------------------------------------------------------
// The entries live in a 64-word single-port-read, single-port-write RAM used
// as a ring: a head pointer marks position 0 so pop just advances it. One
// word goes in at a time; every word gives exactly one response word. Push,
// clear, rejected operations and unknown kinds go straight to the response;
// pop and read first do one RAM read. Ordered insert into a non-empty store
// and erase walk the stored entries through the RAM, one entry per cycle.
// The single RAM read port sets that walk rate. There is no clearing pass
// after reset: the count alone tells which entries hold data. A finished
// response waits in an output register, so the next word is taken while it
// waits.
// ---------------------------------------------------------------------------
module bounded_queue_sorted_insert_top (
   input  logic        clock,
   input  logic        reset,
   bqsi_req_if.sink    req_ch,
   bqsi_rsp_if.source  rsp_ch
);
   import bqsi_pkg::*;

   ram_cmd_type      ram_cmd;
   logic [ENT_W-1:0] ram_rdata;
   logic             res_valid;
   result_type       res;
   logic             res_take;

   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   logic             slot_free;

   bqsi_ram u_ram (
      .clock (clock),
      .cmd   (ram_cmd),
      .rdata (ram_rdata)
   );

   bqsi_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   // Output slot frees up when empty or when its word is taken this cycle.
   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign res_take  = res_valid && slot_free;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (slot_free) begin
         out_valid_in = res_valid;
      end
      // Load only on a transfer; otherwise hold the waiting word.
      if (res_take) begin
         out_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.ok        = out_ff.ok;
   assign rsp_ch.data      = out_ff.data;
   assign rsp_ch.count     = out_ff.count;
   assign rsp_ch.empty_res = out_ff.empty_res;
endmodule

// ----- hdl/bqsi_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqsi_ram
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bqsi_ram (
   input  logic                        clock,
   input  bqsi_pkg::ram_cmd_type       cmd,
   output logic [bqsi_pkg::ENT_W-1:0]  rdata
);
   import bqsi_pkg::*;

   logic [ENT_W-1:0] mem_ff [CAPACITY];
   logic [ENT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem_ff[cmd.waddr] <= cmd.wdata;
      end
      if (cmd.re) begin
         rdata_ff <= mem_ff[cmd.raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- hdl/bqsi_engine.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqsi_engine
// Operation sequencer: ring pointers, entry count and the scan that inserts
// in order or compacts out equal entries, one entry per cycle.
// ---------------------------------------------------------------------------
module bqsi_engine (
   input  logic                        clock,
   input  logic                        reset,
   bqsi_req_if.sink                    req,
   output bqsi_pkg::ram_cmd_type       ram_cmd,
   input  logic [bqsi_pkg::ENT_W-1:0]  ram_rdata,
   output logic                        res_valid,
   output bqsi_pkg::result_type        res,
   input  logic                        res_take
);
   import bqsi_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic                    ins_ff, ins_in;
   logic [ENT_W-1:0]        val_ff, val_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        w_ff, w_in;
   logic [ENT_W-1:0]        carry_ff, carry_in;
   logic                    placed_ff, placed_in;
   logic                    hit_ff, hit_in;
   logic                    ok_ff, ok_in;
   logic signed [VAL_W-1:0] data_ff, data_in;

   logic             val_neg;
   logic             full;
   logic             in_range;
   logic             place;
   logic [PTR_W-1:0] cur_addr;

   assign req.ready = (state_ff == ST_IDLE);
   assign val_neg   = req.value[VAL_W-1];
   assign full      = (fill_ff == CNT_W'(CAPACITY));
   assign in_range  = (k_ff != fill_ff);
   assign cur_addr  = PTR_W'(head_ff + k_ff[PTR_W-1:0]);
   // Head goes in front only when strictly greater; later slots when not less.
   assign place     = (k_ff == '0) ? (val_ff > ram_rdata) : (ram_rdata <= val_ff);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      ins_in    = ins_ff;
      val_in    = val_ff;
      k_in      = k_ff;
      w_in      = w_ff;
      carry_in  = carry_ff;
      placed_in = placed_ff;
      hit_in    = hit_ff;
      ok_in     = ok_ff;
      data_in   = data_ff;
      ram_cmd   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in  = ST_DONE;
               ok_in     = 1'b0;
               data_in   = NO_DATA;
               val_in    = req.value[ENT_W-1:0];
               k_in      = '0;
               w_in      = '0;
               placed_in = 1'b0;
               hit_in    = 1'b0;
               case (req.kind)
                  KIND_PUSH: begin
                     if (!val_neg && !full) begin
                        ram_cmd.we    = 1'b1;
                        ram_cmd.waddr = PTR_W'(head_ff + fill_ff[PTR_W-1:0]);
                        ram_cmd.wdata = req.value[ENT_W-1:0];
                        fill_in       = CNT_W'(fill_ff + 1'b1);
                        ok_in         = 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (fill_ff != '0) begin
                        ram_cmd.re    = 1'b1;
                        ram_cmd.raddr = head_ff;
                        head_in       = PTR_W'(head_ff + 1'b1);
                        fill_in       = CNT_W'(fill_ff - 1'b1);
                        ok_in         = 1'b1;
                        state_in      = ST_READ;
                     end
                  end
                  KIND_INSERT: begin
                     if (!val_neg && !full) begin
                        if (fill_ff == '0) begin
                           ram_cmd.we    = 1'b1;
                           ram_cmd.waddr = head_ff;
                           ram_cmd.wdata = req.value[ENT_W-1:0];
                           fill_in       = CNT_W'(1);
                           ok_in         = 1'b1;
                        end else begin
                           ram_cmd.re    = 1'b1;
                           ram_cmd.raddr = head_ff;
                           ins_in        = 1'b1;
                           state_in      = ST_SCAN;
                        end
                     end
                  end
                  KIND_ERASE: begin
                     if (!val_neg && fill_ff != '0) begin
                        ram_cmd.re    = 1'b1;
                        ram_cmd.raddr = head_ff;
                        ins_in        = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  KIND_READ: begin
                     if (CNT_W'(req.index) < fill_ff) begin
                        ram_cmd.re    = 1'b1;
                        ram_cmd.raddr = PTR_W'(head_ff + PTR_W'(req.index));
                        ok_in         = 1'b1;
                        state_in      = ST_READ;
                     end
                  end
                  KIND_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            data_in  = {1'b0, ram_rdata};
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // Fetch the next slot while the current one is handled.
            ram_cmd.re    = in_range;
            ram_cmd.raddr = PTR_W'(cur_addr + 1'b1);
            if (ins_ff) begin
               if (in_range) begin
                  if (placed_ff) begin
                     ram_cmd.we    = 1'b1;
                     ram_cmd.waddr = cur_addr;
                     ram_cmd.wdata = carry_ff;
                     carry_in      = ram_rdata;
                  end else if (place) begin
                     ram_cmd.we    = 1'b1;
                     ram_cmd.waddr = cur_addr;
                     ram_cmd.wdata = val_ff;
                     carry_in      = ram_rdata;
                     placed_in     = 1'b1;
                  end
                  k_in = CNT_W'(k_ff + 1'b1);
               end else begin
                  ram_cmd.we    = 1'b1;
                  ram_cmd.waddr = cur_addr;
                  ram_cmd.wdata = placed_ff ? carry_ff : val_ff;
                  fill_in       = CNT_W'(fill_ff + 1'b1);
                  ok_in         = 1'b1;
                  state_in      = ST_DONE;
               end
            end else begin
               if (in_range) begin
                  if (ram_rdata == val_ff) begin
                     hit_in = 1'b1;
                  end else begin
                     ram_cmd.we    = 1'b1;
                     ram_cmd.waddr = PTR_W'(head_ff + w_ff[PTR_W-1:0]);
                     ram_cmd.wdata = ram_rdata;
                     w_in          = CNT_W'(w_ff + 1'b1);
                  end
                  k_in = CNT_W'(k_ff + 1'b1);
               end else begin
                  fill_in  = w_ff;
                  ok_in    = hit_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
      ins_ff    <= ins_in;
      val_ff    <= val_in;
      k_ff      <= k_in;
      w_ff      <= w_in;
      carry_ff  <= carry_in;
      placed_ff <= placed_in;
      hit_ff    <= hit_in;
      ok_ff     <= ok_in;
      data_ff   <= data_in;
   end

   assign res_valid     = (state_ff == ST_DONE);
   assign res.ok        = ok_ff;
   assign res.data      = data_ff;
   assign res.count     = fill_ff;
   assign res.empty_res = (fill_ff == '0);
endmodule

// ----- hdl/bqsi_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bqsi_checker
// Port-level checks of the sorted queue block, bound to the top level.
// ---------------------------------------------------------------------------
`include "bounded_queue_sorted_insert_top_macros.svh"

module bqsi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_ok,
   input logic signed [bqsi_pkg::VAL_W-1:0] rsp_data,
   input logic [bqsi_pkg::CNT_W-1:0]        rsp_count,
   input logic                              rsp_empty_res
);
   import bqsi_pkg::*;

   `BQSI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_count), "response word changed while stalled")
   `BQSI_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while an operation is in flight")
   `BQSI_ASSERT_IMPL(a_fail_no_data, rsp_valid && !rsp_ok, rsp_data == NO_DATA, "failed operation returned data")
   `BQSI_ASSERT_IMPL(a_count_range, rsp_valid, (rsp_count <= CNT_W'(CAPACITY)) && (rsp_empty_res == (rsp_count == '0)), "count out of range or empty flag mismatch")
endmodule

bind bounded_queue_sorted_insert_top bqsi_checker u_bqsi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_ok        (rsp_ch.ok),
   .rsp_data      (rsp_ch.data),
   .rsp_count     (rsp_ch.count),
   .rsp_empty_res (rsp_ch.empty_res)
);

// ----- test/tb_bounded_queue_sorted_insert_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bounded_queue_sorted_insert_top
// Self-checking bench for the sorted queue: a clocked driver feeds operation
// words from a pending list, a shadow copy of the store predicts every
// response, and a clocked monitor compares each response word field by field.
// ---------------------------------------------------------------------------
module tb_bounded_queue_sorted_insert_top;
   import bqsi_pkg::*;

   // Kinds 6 and 7 have no operation; the block must answer them as no-ops.
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   localparam int DIRECTED_WORDS = 25;
   localparam int RANDOM_WORDS   = 1000;
   // Leave room for the longest walk and for a drained output register.
   localparam int SETTLE_CYCLES  = 80;
   // Receiver holds off this long once, so the block backs up into the driver.
   localparam int BACKLOG_CYCLES = 300;
   localparam int BACKLOG_AFTER  = 400;

   typedef struct {
      logic [KIND_W-1:0]       kind;
      logic signed [VAL_W-1:0] value;
      logic [IDX_W-1:0]        index;
      bit                      drain_first;  // hold this word until all responses are in
   } queue_op_type;

   logic clock = 1'b0;
   logic reset;

   bqsi_req_if req_bus ();
   bqsi_rsp_if rsp_bus ();

   bounded_queue_sorted_insert_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #6 clock = ~clock;

   // Shadow copy of the store: entries from head (0) to tail (fill-1).
   logic [ENT_W-1:0] shadow_store [CAPACITY];
   int               shadow_fill;

   queue_op_type pending_ops [$];
   result_type   awaited_results [$];
   queue_op_type offer_op;
   bit           offer_live;
   int           total_words;
   int           words_sent;
   int           results_seen;
   int           mismatches;
   int           backlog_hold;
   bit           backlog_done;

   // -------------------------------------------------------------------------
   // Prediction: apply one operation to the shadow store, return its response.
   // -------------------------------------------------------------------------
   function automatic result_type queue_op_result(queue_op_type op);
      result_type       r;
      logic [ENT_W-1:0] v31;
      bit               is_neg;
      int               pos;
      int               w;
      r.ok   = 1'b0;
      r.data = NO_DATA;
      v31    = op.value[ENT_W-1:0];
      is_neg = op.value[VAL_W-1];
      case (op.kind)
         KIND_PUSH: begin
            // Reject negatives and a full store; state stays as it was.
            if (!is_neg && shadow_fill < CAPACITY) begin
               shadow_store[shadow_fill] = v31;
               shadow_fill++;
               r.ok = 1'b1;
            end
         end
         KIND_POP: begin
            if (shadow_fill > 0) begin
               r.data = {1'b0, shadow_store[0]};
               for (int i = 1; i < shadow_fill; i++)
                  shadow_store[i-1] = shadow_store[i];
               shadow_fill--;
               r.ok = 1'b1;
            end
         end
         KIND_INSERT: begin
            if (!is_neg && shadow_fill < CAPACITY) begin
               // Head is special: only a strictly greater value displaces it.
               // Past the head, skip every entry greater than the new value.
               if (shadow_fill == 0 || v31 > shadow_store[0]) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < shadow_fill && shadow_store[pos] > v31)
                     pos++;
               end
               for (int i = shadow_fill; i > pos; i--)
                  shadow_store[i] = shadow_store[i-1];
               shadow_store[pos] = v31;
               shadow_fill++;
               r.ok = 1'b1;
            end
         end
         KIND_ERASE: begin
            // Drop every equal entry and close the gaps; negatives match nothing.
            if (!is_neg) begin
               w = 0;
               for (int i = 0; i < shadow_fill; i++) begin
                  if (shadow_store[i] == v31) begin
                     r.ok = 1'b1;
                  end else begin
                     shadow_store[w] = shadow_store[i];
                     w++;
                  end
               end
               shadow_fill = w;
            end
         end
         KIND_READ: begin
            if (int'(op.index) < shadow_fill) begin
               r.data = {1'b0, shadow_store[op.index]};
               r.ok   = 1'b1;
            end
         end
         KIND_CLEAR: begin
            shadow_fill = 0;
         end
         default: begin
         end
      endcase
      r.count     = CNT_W'(shadow_fill);
      r.empty_res = (shadow_fill == 0);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   function automatic void add_op(logic [KIND_W-1:0] kind, logic signed [VAL_W-1:0] value,
                                  logic [IDX_W-1:0] index, bit drain_first);
      queue_op_type op;
      op.kind        = kind;
      op.value       = value;
      op.index       = index;
      op.drain_first = drain_first;
      pending_ops.push_back(op);
   endfunction

   // Mostly a small pool so erase and duplicate inserts hit; the rest covers
   // the full 32-bit range, negatives and the extremes.
   function automatic logic signed [VAL_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return $urandom_range(0, 15);
      if (roll < 80) return $urandom() & 32'h7FFF_FFFF;
      if (roll < 92) return $urandom() | 32'h8000_0000;
      case ($urandom_range(0, 3))
         0:       return 32'sd0;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sd1;
         default: return 32'sh8000_0000;
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      if ($urandom_range(1)) return IDX_W'($urandom_range(0, 63));
      return IDX_W'($urandom_range(0, 15));
   endfunction

   task automatic build_stimulus();
      int                mode;
      int                len;
      int                roll;
      logic [KIND_W-1:0] kind;
      // Empty store: pop, read and erase all miss.
      add_op(KIND_POP,    0, 0, 0);
      add_op(KIND_READ,   0, 0, 0);
      add_op(KIND_ERASE,  5, 0, 0);
      // Insert into empty goes to the head; equal to head lands behind it.
      add_op(KIND_INSERT, 32'sh7FFF_FFFF, 0, 0);
      add_op(KIND_INSERT, 0, 0, 0);
      add_op(KIND_INSERT, 32'sh7FFF_FFFF, 0, 0);
      // Negative values are rejected by push and insert.
      add_op(KIND_PUSH,   -32'sd1, 0, 0);
      add_op(KIND_INSERT, 32'sh8000_0000, 0, 0);
      add_op(KIND_INSERT, 100, 0, 0);
      add_op(KIND_INSERT, 100, 0, 0);
      add_op(KIND_PUSH,   100, 0, 0);
      add_op(KIND_INSERT, 200, 0, 0);
      // Read far out of range, an inner entry, the tail and one past the tail.
      add_op(KIND_READ,   0, 6'd63, 0);
      add_op(KIND_READ,   0, 6'd1, 0);
      add_op(KIND_READ,   0, 6'd6, 0);
      add_op(KIND_READ,   0, 6'd7, 0);
      // Erase several equal entries, then a negative and a missing value.
      add_op(KIND_ERASE,  100, 0, 0);
      add_op(KIND_ERASE,  -32'sd5, 0, 0);
      add_op(KIND_ERASE,  12345, 0, 0);
      add_op(KIND_SPARE_A, 7, 6'd1, 0);
      add_op(KIND_SPARE_B, -32'sd1, 6'd63, 0);
      add_op(KIND_POP,    0, 0, 0);
      add_op(KIND_CLEAR,  0, 0, 0);
      add_op(KIND_PUSH,   0, 0, 0);
      add_op(KIND_CLEAR,  0, 0, 0);

      // Random bursts: fill runs push the store to full, drain runs empty it,
      // mixed runs throw every kind at the state left, others insert, erase, read.
      while (pending_ops.size() < DIRECTED_WORDS + RANDOM_WORDS) begin
         mode = $urandom_range(0, 3);
         len  = $urandom_range(10, 90);
         for (int n = 0; n < len; n++) begin
            roll = $urandom_range(99);
            case (mode)
               0: kind = (roll < 45) ? KIND_PUSH : (roll < 85) ? KIND_INSERT :
                         (roll < 95) ? KIND_READ : KIND_POP;
               1: kind = (roll < 35) ? KIND_POP : (roll < 60) ? KIND_ERASE :
                         (roll < 85) ? KIND_READ : (roll < 92) ? KIND_INSERT : KIND_PUSH;
               2: begin
                  kind = KIND_W'($urandom_range(0, 7));
                  // Keep clears rare so the store gets a chance to grow.
                  if (kind == KIND_CLEAR && roll >= 20) kind = KIND_READ;
               end
               default: kind = (roll < 60) ? KIND_INSERT : (roll < 80) ? KIND_ERASE :
                               KIND_READ;
            endcase
            // First random word, and now and then a burst start, waits for
            // the pipe to empty completely.
            add_op(kind, pick_value(), pick_index(),
                   (pending_ops.size() == DIRECTED_WORDS) ||
                   (n == 0 && $urandom_range(7) == 0));
         end
         if ($urandom_range(9) == 0) add_op(KIND_CLEAR, pick_value(), pick_index(), 0);
      end
   endtask

   // Idle profile: sender 20 / receiver 56 percent, then swapped, then none.
   function automatic int sender_idle_pct();
      if (words_sent * 3 < total_words) return 20;
      if (words_sent * 3 < total_words * 2) return 56;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (words_sent * 3 < total_words) return 56;
      if (words_sent * 3 < total_words * 2) return 20;
      return 0;
   endfunction

   task automatic log_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatches++;
   endtask

   // -------------------------------------------------------------------------
   // Driver: offer one word at a time; predict it on the edge it is taken.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      bit launch;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_results.push_back(queue_op_result(offer_op));
            words_sent++;
            offer_live = 1'b0;
         end
         if (!offer_live && pending_ops.size() != 0) begin
            launch = 1'b1;
            // Hold a drain word until every response is back.
            if (pending_ops[0].drain_first && awaited_results.size() != 0) launch = 1'b0;
            if ($urandom_range(99) < sender_idle_pct()) launch = 1'b0;
            if (launch) begin
               offer_op   = pending_ops.pop_front();
               offer_live = 1'b1;
               req_bus.kind  <= offer_op.kind;
               req_bus.value <= offer_op.value;
               req_bus.index <= offer_op.index;
            end
         end
         // One assignment per edge keeps valid steady across back-to-back words.
         req_bus.valid <= offer_live;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check each taken response word against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_results.size() == 0) begin
               log_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                      results_seen));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_bus.ok !== want.ok)
                  log_mismatch($sformatf("response %0d ok got %0b want %0b",
                                         results_seen, rsp_bus.ok, want.ok));
               if (rsp_bus.data !== want.data)
                  log_mismatch($sformatf("response %0d data got %0d want %0d",
                                         results_seen, rsp_bus.data, want.data));
               if (rsp_bus.count !== want.count)
                  log_mismatch($sformatf("response %0d count got %0d want %0d",
                                         results_seen, rsp_bus.count, want.count));
               if (rsp_bus.empty_res !== want.empty_res)
                  log_mismatch($sformatf("response %0d empty got %0b want %0b",
                                         results_seen, rsp_bus.empty_res, want.empty_res));
            end
            results_seen++;
         end
         // One long hold-off mid-run, so the block backs up and stalls the driver.
         if (backlog_hold > 0) begin
            backlog_hold--;
         end else if (!backlog_done && words_sent >= BACKLOG_AFTER) begin
            backlog_done = 1'b1;
            backlog_hold = BACKLOG_CYCLES;
         end
         rsp_bus.ready <= (backlog_hold == 0) && ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // -------------------------------------------------------------------------
   // Run control: build stimulus, reset, wait for the traffic to drain.
   // -------------------------------------------------------------------------
   initial begin : run_ctrl
      // Drive every block input to a known value from time zero.
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.kind   = KIND_PUSH;
      req_bus.value  = '0;
      req_bus.index  = '0;
      rsp_bus.ready  = 1'b0;
      offer_live     = 1'b0;
      words_sent     = 0;
      results_seen   = 0;
      mismatches     = 0;
      backlog_hold   = 0;
      backlog_done   = 1'b0;
      shadow_fill    = 0;
      build_stimulus();
      total_words = pending_ops.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || offer_live) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      // Give any stray response a chance to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb_bounded_queue_sorted_insert_top: PASS");
      end else begin
         $display("tb_bounded_queue_sorted_insert_top: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (every word a full walk).
   initial begin : watchdog
      #(8_000_000);
      $display("tb_bounded_queue_sorted_insert_top: FAIL");
      $finish;
   end

endmodule
